// ===== hw/rtl/pdao_pkg.sv =====
// Package for the pixel difference alpha overlay unit.
// Holds the channel width constants and the per-stage payload type.
// No dependencies.
`default_nettype none
package pdao_pkg;
    localparam int ChW   = 8;
    localparam int QW    = 8;     // quotient bits developed, one per cell
    localparam int NumW  = 17;    // 255*n scale, non-negative magnitudes
    localparam logic [7:0] ChMax = 8'd255;

    // One channel's divider working set.
    typedef struct packed {
        logic [NumW-1:0] rem;
        logic [QW-1:0]   quo;
        logic [ChW-1:0]  den;
        logic            neg;
    } div_lane_t;
endpackage
`default_nettype wire

// ===== hw/rtl/pixel_difference_alpha_overlay_unit.sv =====
// Pixel difference alpha overlay unit.
// Item streams: s_axis carries {new_pixel, old_pixel}, m_axis the overlay pixel.
// One item is accepted per cycle while the output register is not stalled.
// Two chains of restoring divide cells do the work: the first, eight cells,
// finds the per-channel alphas (dividends up to 255*255 over an 8-bit divisor),
// a register stage then reduces them to the overlay alpha and forms the solve
// numerators, and the second, nine cells, divides those by the alpha. Solve
// quotients can reach nine bits, so the first solve cell only reduces the
// remainder and the other cells yield the low quotient byte. The whole chain
// advances together, so a stall at m_axis_tready holds every item in place;
// s_axis_tready is high whenever the output register is empty or being taken,
// which keeps one item a cycle flowing while the receiver takes them. Reset
// clears all valid flags. The output register sits after the last cell.
`default_nettype none
module pixel_difference_alpha_overlay_unit
    import pdao_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // old_pixel[31:0], new_pixel[63:32]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata    // overlay_pixel[31:0]
);
    localparam int SideW = 64 + 4;   // pixels, equal flag, per-lane "old>new"

    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Stage A setup: dividend and divisor per lane for the alpha search.
    logic [31:0] op, np;
    assign op = s_axis_tdata[31:0];
    assign np = s_axis_tdata[63:32];

    div_lane_t         a_lane [9][3];
    logic              a_vld  [9];
    logic [SideW-1:0]  a_side [9];
    logic [2:0]        gt;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [7:0] o, n;
            o = op[16-8*i +: 8];
            n = np[16-8*i +: 8];
            gt[i] = o > n;
            a_lane[0][i].quo = '0;
            a_lane[0][i].neg = (o == n);
            if (o > n) begin
                a_lane[0][i].rem = NumW'(n) * NumW'(ChMax);
                a_lane[0][i].den = o;
            end else begin
                a_lane[0][i].rem = NumW'(n - o) * NumW'(ChMax);
                a_lane[0][i].den = (o == n) ? 8'd1 : ChMax - o;
            end
        end
    end
    assign a_vld[0]  = s_axis_tvalid;
    assign a_side[0] = {gt, op == np, np, op};

    for (genvar k = 0; k < 8; k++) begin : g_alpha
        pdao_div_cell #(.BitPos(7 - k), .SideW(SideW)) u_cell (
            .aclk, .aresetn, .en,
            .vld_in(a_vld[k]), .lane_in(a_lane[k]), .side_in(a_side[k]),
            .vld_out(a_vld[k+1]), .lane_out(a_lane[k+1]), .side_out(a_side[k+1])
        );
    end

    // Alpha reduction and numerator setup, registered.
    logic [7:0] ach [3];
    logic [7:0] amax;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (a_lane[8][i].neg)
                ach[i] = '0;
            else if (a_side[8][65+i])
                ach[i] = ChMax - a_lane[8][i].quo;
            else
                ach[i] = a_lane[8][i].quo;
        end
        amax = ach[0];
        if (ach[1] > amax) amax = ach[1];
        if (ach[2] > amax) amax = ach[2];
    end

    logic             m_vld_reg;
    div_lane_t        m_lane_reg [3];
    logic [SideW-1:0] m_side_reg;
    logic [7:0]       m_alpha_reg;
    div_lane_t        m_lane_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [7:0] o, n;
            logic signed [17:0] num;
            o = a_side[8][16-8*i +: 8];
            n = a_side[8][48-8*i +: 8];
            num = $signed({1'b0, NumW'(n) * NumW'(ChMax)})
                - $signed({1'b0, NumW'(o) * NumW'(ChMax - amax)});
            m_lane_next[i].neg = num[17];
            m_lane_next[i].rem = num[17] ? NumW'(-num) : num[NumW-1:0];
            m_lane_next[i].den = (amax == 8'd0) ? 8'd1 : amax;
            m_lane_next[i].quo = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (en) begin
            m_vld_reg <= a_vld[8];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_lane_reg  <= m_lane_next;
            m_side_reg  <= a_side[8];
            m_alpha_reg <= amax;
        end
    end

    // Solve chain; alpha travels in the spare side bits.
    localparam int SW2 = 64 + 9;
    div_lane_t        b_lane [10][3];
    logic             b_vld  [10];
    logic [SW2-1:0]   b_side [10];
    assign b_lane[0] = m_lane_reg;
    assign b_vld[0]  = m_vld_reg;
    assign b_side[0] = {m_side_reg[64], m_alpha_reg, m_side_reg[63:0]};

    for (genvar k = 0; k < 9; k++) begin : g_solve
        pdao_div_cell #(.BitPos(8 - k), .SideW(SW2)) u_cell (
            .aclk, .aresetn, .en,
            .vld_in(b_vld[k]), .lane_in(b_lane[k]), .side_in(b_side[k]),
            .vld_out(b_vld[k+1]), .lane_out(b_lane[k+1]), .side_out(b_side[k+1])
        );
    end

    // The chain leaves the low byte of each quotient magnitude; the sign is
    // applied here, still modulo 256.
    logic [31:0] res_next;
    logic [7:0]  fa;
    logic [7:0]  qb [3];
    always_comb begin
        fa = b_side[9][71:64];
        for (int i = 0; i < 3; i++) begin
            qb[i] = b_lane[9][i].neg ? -b_lane[9][i].quo : b_lane[9][i].quo;
        end
        if (b_side[9][72] || fa == 8'd0)
            res_next = '0;
        else if (fa == ChMax)
            res_next = b_side[9][63:32];
        else
            res_next = {fa, qb[0], qb[1], qb[2]};
    end

    logic        o_vld_reg;
    logic [31:0] o_data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_vld_reg <= 1'b0;
        end else if (en) begin
            o_vld_reg <= b_vld[9];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            o_data_reg <= res_next;
        end
    end

    assign m_axis_tvalid = o_vld_reg;
    assign m_axis_tdata  = o_data_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/pdao_div_cell.sv =====
// One restoring division step for three channel lanes.
// Uses pdao_pkg. Each cell produces one quotient bit per lane, then registers.
`default_nettype none
module pdao_div_cell
    import pdao_pkg::*;
#(
    parameter int BitPos = 7,
    parameter int SideW  = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             vld_in,
    input  wire div_lane_t        lane_in  [3],
    input  wire logic [SideW-1:0] side_in,
    output logic                  vld_out,
    output div_lane_t             lane_out [3],
    output logic      [SideW-1:0] side_out
);
    div_lane_t       lane_next [3];
    logic            vld_reg;
    div_lane_t       lane_reg  [3];
    logic [SideW-1:0] side_reg;

    // A step above the quotient width still reduces the remainder, but its
    // quotient bit falls outside the kept low byte.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [NumW+QW-1:0] sh;
            logic [QW:0]        qmask;
            sh = (NumW+QW)'(lane_in[i].den) << BitPos;
            qmask = (QW+1)'(1) << BitPos;
            lane_next[i] = lane_in[i];
            if ({{QW{1'b0}}, lane_in[i].rem} >= sh) begin
                lane_next[i].rem = lane_in[i].rem - sh[NumW-1:0];
                lane_next[i].quo = lane_in[i].quo | qmask[QW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign lane_out = lane_reg;
    assign side_out = side_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/pdao_checker.sv =====
// Port-level checker for the pixel difference alpha overlay unit.
// Depends only on the top level's ports; bound to it below.
`default_nettype none
module pdao_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);
    // The input side only stalls when the output is blocked.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled while output free");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled item changed");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");
endmodule

bind pixel_difference_alpha_overlay_unit pdao_checker u_pdao_checker (
    .aclk, .aresetn, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire

// ===== test/pixel_difference_alpha_overlay_unit_tb.sv =====
// Testbench for the pixel difference alpha overlay unit.
// Drives old/new pixel pairs with random gaps and stalls and checks each overlay pixel
// against a predictor of the blend solve. Depends on pdao_pkg and the unit itself.
`default_nettype none
module pixel_difference_alpha_overlay_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pdao_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    pixel_difference_alpha_overlay_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #10 aclk = ~aclk;

    logic [63:0] pending_pairs[$];
    logic [31:0] expected_overlays[$];
    int          mismatches = 0;
    int          checked = 0;
    int          unexpected = 0;
    bit          stim_done = 1'b0;
    bit          hold_sender = 1'b0;
    bit          long_stall = 1'b0;

    function automatic void add_pair(logic [63:0] pr);
        pending_pairs = {pending_pairs, pr};
    endfunction

    function automatic void add_expected(logic [31:0] ov);
        expected_overlays = {expected_overlays, ov};
    endfunction

    // Smallest alpha one channel needs to reach n from o.
    function automatic int channel_alpha(int o, int n);
        if (o == n) return 0;
        if (o > n) return 255 - (255 * n) / o;
        return (255 * (n - o)) / (255 - o);
    endfunction

    function automatic logic [31:0] predict_overlay(logic [31:0] oldp, logic [31:0] newp);
        int a, ca, o, n, num, q;
        logic [31:0] res;
        if (oldp == newp) return 32'd0;
        a = 0;
        for (int c = 0; c < 3; c++) begin
            ca = channel_alpha(int'(oldp[c*8 +: 8]), int'(newp[c*8 +: 8]));
            if (ca > a) a = ca;
        end
        if (a == 0) return 32'd0;
        if (a >= 255) return newp;
        res = '0;
        res[31:24] = a[7:0];
        for (int c = 0; c < 3; c++) begin
            o = int'(oldp[c*8 +: 8]);
            n = int'(newp[c*8 +: 8]);
            num = 255 * n - o * (255 - a);
            q = num / a;   // SystemVerilog int division truncates toward zero
            res[c*8 +: 8] = q[7:0];
        end
        return res;
    endfunction

    // Driver: each item draws the idle cycles that follow its acceptance.
    int send_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                add_expected(predict_overlay(s_axis_tdata[31:0], s_axis_tdata[63:32]));
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // keep offering the same item
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (hold_sender || pending_pairs.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tdata  <= pending_pairs.pop_front();
                s_axis_tvalid <= 1'b1;
                send_gap      <= $urandom_range(0, 3);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off while the sender keeps going.
    int recv_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_overlays.size() == 0) begin
                    unexpected++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected overlay item %08h", m_axis_tdata);
                end else begin
                    logic [31:0] exp_v;
                    exp_v = expected_overlays.pop_front();
                    checked++;
                    if (exp_v !== m_axis_tdata) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("overlay mismatch: expected %08h, got %08h",
                                     exp_v, m_axis_tdata);
                    end
                end
            end
            if (long_stall) begin
                m_axis_tready <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                recv_gap = $urandom_range(0, 3);
                m_axis_tready <= (recv_gap == 0);
            end else if (!m_axis_tready && recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= (recv_gap == 0);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off, timed in cycles here while the sender keeps offering items.
    initial begin
        wait (aresetn);
        repeat (60) @(posedge aclk);
        long_stall <= 1'b1;
        repeat (120) @(posedge aclk);
        long_stall <= 1'b0;
    end

    function automatic logic [31:0] rand_pixel();
        return $urandom();
    endfunction

    // Pixel pair whose channels differ by a small amount, so partial alphas are common.
    function automatic logic [63:0] near_pair();
        logic [31:0] o, n;
        int d;
        o = rand_pixel();
        n = o;
        for (int c = 0; c < 4; c++) begin
            if ($urandom_range(0, 2) != 0) begin
                d = $urandom_range(0, 80) - 40;
                n[c*8 +: 8] = o[c*8 +: 8] + d[7:0];
            end
        end
        return {n, o};
    endfunction

    initial begin
        logic [31:0] p;
        // Directed pairs: {new, old}.
        add_pair({32'h0000_0000, 32'h0000_0000});
        add_pair({32'hffff_ffff, 32'hffff_ffff});
        add_pair({32'h1234_5678, 32'h1234_5678});
        add_pair({32'hff12_3456, 32'h0012_3456});   // alpha byte only
        add_pair({32'hffff_ffff, 32'h0000_0000});   // full alpha
        add_pair({32'h0000_0000, 32'hffff_ffff});
        add_pair({32'h00ff_0000, 32'h0000_0000});
        add_pair({32'h0000_00ff, 32'h0000_00fe});
        add_pair({32'h0000_00fe, 32'h0000_00ff});
        add_pair({32'h0000_0001, 32'h0000_0000});
        add_pair({32'h0000_0000, 32'h0000_0001});
        add_pair({32'h0080_8080, 32'h0040_4040});
        add_pair({32'h0040_4040, 32'h0080_8080});
        add_pair({32'h00ff_00ff, 32'h0000_ff00});
        add_pair({32'h0011_2233, 32'h00fe_0102});
        add_pair({32'haa10_2030, 32'h5512_1f33});
        add_pair({32'h0081_0080, 32'h0080_0081});
        add_pair({32'h00c8_6432, 32'h0064_c819});
        for (int i = 0; i < 750; i++) begin
            if ($urandom_range(0, 9) < 6) add_pair(near_pair());
            else if ($urandom_range(0, 9) == 0) begin
                p = rand_pixel();
                add_pair({p, p});
            end else add_pair({rand_pixel(), rand_pixel()});
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Sender pause until the pipe has fully drained.
        wait (pending_pairs.size() < 400);
        @(posedge aclk);
        hold_sender <= 1'b1;
        wait (!s_axis_tvalid && expected_overlays.size() == 0);
        @(posedge aclk);
        hold_sender <= 1'b0;

        wait (pending_pairs.size() == 0 && !s_axis_tvalid);
        wait (expected_overlays.size() == 0);
        repeat (40) @(posedge aclk);
        $display("Checked %0d overlay items: equal pairs, alpha-only changes, full and",
                 checked);
        $display("partial alphas, with random gaps and a long output stall.");
        if (mismatches == 0 && expected_overlays.size() == 0)
            $display("pixel_difference_alpha_overlay_unit_tb: done, clean");
        else
            $display("pixel_difference_alpha_overlay_unit_tb: done, errors");
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout waiting for overlay items");
        $display("pixel_difference_alpha_overlay_unit_tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
